/* hw/rtl/mcu_serial_frame_deframer_defines.svh */
// ----------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Shared concurrent assertion shorthands for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef MCU_SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define MCU_SERIAL_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define MCUSFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, checked outside of reset.
`define MCUSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

/* hw/rtl/mcusfd_pkg.sv */
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Frame codes, header and command constants, and shared payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcusfd_pkg;

   // Window geometry.
   localparam int WinLen    = 6;
   localparam int FillWidth = 3;

   // Frame header and command bytes.
   localparam logic [7:0] HDR_PRESS    = 8'h61;
   localparam logic [7:0] HDR_RELEASE  = 8'hE1;
   localparam logic [7:0] HDR_LINK     = 8'h5C;
   localparam logic [7:0] LINK_LEN     = 8'h01;
   localparam logic [7:0] TYPE_DISPLAY = 8'h02;
   localparam logic [7:0] DISP_RGB     = 8'h01;
   localparam logic [7:0] DISP_IO      = 8'h02;
   localparam logic [7:0] TYPE_STATUS  = 8'h08;
   localparam logic [7:0] TYPE_VOLUME  = 8'h10;
   localparam logic [7:0] TYPE_ANSWER  = 8'h11;

   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_LINK    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_RGB     = 3'd1,
      ACT_IO      = 3'd2,
      ACT_STATUS  = 3'd3,
      ACT_VOLUME  = 3'd4,
      ACT_ANSWER  = 3'd5
   } action_type;

   // One six-byte window, oldest byte at index 0.
   typedef logic [WinLen-1:0][7:0] window_type;

   typedef struct packed {
      kind_type   frame_kind;
      action_type action;
      logic [15:0] touch_x;
      logic [15:0] touch_y;
      logic [7:0]  cmd_type;
      logic [7:0]  cmd_data;
   } result_type;

   // Verdict of the frame check on a full window.
   typedef struct packed {
      logic       hit;
      result_type result;
   } verdict_type;

endpackage

`default_nettype wire

/* hw/rtl/mcusfd_req_if.sv */
// ----------------------------------------------------------------------------
// Deframer byte channel
// Valid/ready channel carrying one received serial byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcusfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mcusfd_rsp_if.sv */
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying one decoded frame per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcusfd_rsp_if;
   logic                   valid;
   logic                   ready;
   mcusfd_pkg::kind_type   frame_kind;
   mcusfd_pkg::action_type action;
   logic [15:0]            touch_x;
   logic [15:0]            touch_y;
   logic [7:0]             cmd_type;
   logic [7:0]             cmd_data;

   modport source (output valid, output frame_kind, output action, output touch_x,
                   output touch_y, output cmd_type, output cmd_data, input ready);
   modport sink   (input valid, input frame_kind, input action, input touch_x,
                   input touch_y, input cmd_type, input cmd_data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mcusfd_frame_check.sv */
// ----------------------------------------------------------------------------
// Deframer frame check
// Checks a full six-byte window for a touch or link frame and decodes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mcusfd_frame_check (
   input  mcusfd_pkg::window_type  frame,
   output mcusfd_pkg::verdict_type verdict
);

   logic                   sum_ok;
   mcusfd_pkg::action_type link_act;

   // The check byte is the XOR of the five bytes before it.
   assign sum_ok = ((frame[0] ^ frame[1] ^ frame[2] ^ frame[3] ^ frame[4]) == frame[5]);

   // Command action of a link frame, from its type and data bytes.
   always_comb begin
      priority if (frame[3] == mcusfd_pkg::TYPE_DISPLAY) begin
         priority if (frame[4] == mcusfd_pkg::DISP_RGB) begin
            link_act = mcusfd_pkg::ACT_RGB;
         end else if (frame[4] == mcusfd_pkg::DISP_IO) begin
            link_act = mcusfd_pkg::ACT_IO;
         end else begin
            link_act = mcusfd_pkg::ACT_NONE;
         end
      end else if (frame[3] == mcusfd_pkg::TYPE_STATUS) begin
         link_act = mcusfd_pkg::ACT_STATUS;
      end else if (frame[3] == mcusfd_pkg::TYPE_VOLUME) begin
         link_act = mcusfd_pkg::ACT_VOLUME;
      end else if (frame[3] == mcusfd_pkg::TYPE_ANSWER) begin
         link_act = mcusfd_pkg::ACT_ANSWER;
      end else begin
         link_act = mcusfd_pkg::ACT_NONE;
      end
   end

   // Header decides the frame kind; touch frames win over link frames.
   always_comb begin
      verdict.hit                = 1'b0;
      verdict.result.frame_kind  = mcusfd_pkg::KIND_PRESS;
      verdict.result.action      = mcusfd_pkg::ACT_NONE;
      verdict.result.touch_x     = {frame[1], frame[2]};
      verdict.result.touch_y     = {frame[3], frame[4]};
      verdict.result.cmd_type    = '0;
      verdict.result.cmd_data    = '0;
      priority if (!sum_ok) begin
         verdict.hit = 1'b0;
      end else if (frame[0] == mcusfd_pkg::HDR_PRESS) begin
         verdict.hit = 1'b1;
      end else if (frame[0] == mcusfd_pkg::HDR_RELEASE) begin
         verdict.hit               = 1'b1;
         verdict.result.frame_kind = mcusfd_pkg::KIND_RELEASE;
      end else if (frame[0] == mcusfd_pkg::HDR_LINK && frame[2] == mcusfd_pkg::LINK_LEN) begin
         verdict.hit               = 1'b1;
         verdict.result.frame_kind = mcusfd_pkg::KIND_LINK;
         verdict.result.action     = link_act;
         verdict.result.touch_x    = '0;
         verdict.result.touch_y    = '0;
         verdict.result.cmd_type   = frame[3];
         verdict.result.cmd_data   = frame[4];
      end else begin
         verdict.hit = 1'b0;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/mcu_serial_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Serial frame deframer
// Finds touch and link frames in a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one received serial byte per transfer, oldest first.
//   rsp_ch carries one decoded frame per transfer: kind, action, touch
//   coordinates and link command bytes.
//   A byte moves first into an input register; when the work stage moves,
//   it joins the stored window and the frame check runs, and a found frame
//   lands in the result register, from which rsp_ch offers it.
//   One byte per cycle is taken in steady state while results are taken;
//   the window update and the XOR check are combinational between the
//   input and result registers.
//   Most bytes make no result; a frame clears the window, a miss drops the
//   oldest byte and keeps five.
//   Reset empties the window and both registers.
//   When the receiver stalls with a result waiting, the input register still
//   fills once, then req_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mcu_serial_frame_deframer_defines.svh"

module mcu_serial_frame_deframer (
   input  wire          clock,
   input  wire          reset,
   mcusfd_req_if.sink   req_ch,
   mcusfd_rsp_if.source rsp_ch
);

   localparam int StoreLen = mcusfd_pkg::WinLen - 1;
   localparam logic [mcusfd_pkg::FillWidth-1:0] LastFill =
      mcusfd_pkg::FillWidth'(StoreLen);

   logic                                 in_valid_ff, in_valid_in;
   logic [7:0]                           in_byte_ff;
   logic [StoreLen-1:0][7:0]             win_ff, win_in;
   logic [mcusfd_pkg::FillWidth-1:0]     fill_ff, fill_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   mcusfd_pkg::result_type               rsp_data_ff, rsp_data_in;
   logic                                 advance;
   mcusfd_pkg::window_type               frame;
   mcusfd_pkg::verdict_type              verdict;

   // The work stage moves when the result register is free or being drained.
   assign advance       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !in_valid_ff || advance;
   assign in_valid_in   = req_ch.ready ? req_ch.valid : in_valid_ff;

   // Stored bytes plus the newest byte form the window under test.
   assign frame = {in_byte_ff, win_ff};

   mcusfd_frame_check u_check (
      .frame   (frame),
      .verdict (verdict)
   );

   // Window update and result capture.
   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (in_valid_ff) begin
            if (fill_ff != LastFill) begin
               for (int i = 0; i < StoreLen; i++) begin
                  if (fill_ff == mcusfd_pkg::FillWidth'(i)) begin
                     win_in[i] = in_byte_ff;
                  end
               end
               fill_in = fill_ff + mcusfd_pkg::FillWidth'(1);
            end else if (verdict.hit) begin
               fill_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = verdict.result;
            end else begin
               win_in  = {in_byte_ff, win_ff[StoreLen-1:1]};
               fill_in = LastFill;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Result channel outputs.
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.frame_kind = rsp_data_ff.frame_kind;
   assign rsp_ch.action     = rsp_data_ff.action;
   assign rsp_ch.touch_x    = rsp_data_ff.touch_x;
   assign rsp_ch.touch_y    = rsp_data_ff.touch_y;
   assign rsp_ch.cmd_type   = rsp_data_ff.cmd_type;
   assign rsp_ch.cmd_data   = rsp_data_ff.cmd_data;

   // The fill count never reaches a full window between bytes.
   `MCUSFD_ASSERT_NOW(a_fill_range, clock, reset, 1'b1, fill_ff <= LastFill)
   // A found frame empties the window.
   `MCUSFD_ASSERT_NEXT(a_hit_clears, clock, reset,
      advance && in_valid_ff && fill_ff == LastFill && verdict.hit, fill_ff == '0)
   // A new result only follows a byte in the work stage.
   `MCUSFD_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(in_valid_ff))
   // Link results carry no touch coordinates.
   `MCUSFD_ASSERT_NOW(a_link_no_touch, clock, reset,
      rsp_valid_ff && rsp_data_ff.frame_kind == mcusfd_pkg::KIND_LINK,
      rsp_data_ff.touch_x == '0 && rsp_data_ff.touch_y == '0)

endmodule

`default_nettype wire
